@@ sv/fthp_pkg.sv @@
// shared types and constants for the frame time percentile health monitor
`timescale 1ns / 1ps
package fthp_pkg;

  localparam int FT_W = 20;
  localparam logic [FT_W-1:0] FRAME_MAX_US = 20'd1000000;
  localparam int MIN_SAMPLES = 4;
  localparam logic [17:0] RECIP_100 = 18'd167773;
  localparam int RECIP_SHIFT = 24;

  localparam logic [1:0] KIND_RECORD = 2'd0;
  localparam logic [1:0] KIND_BAD = 2'd1;
  localparam logic [1:0] KIND_ASSESS = 2'd2;

  localparam logic [2:0] ISS_NONE = 3'd0;
  localparam logic [2:0] ISS_MEMORY = 3'd1;
  localparam logic [2:0] ISS_STUTTER = 3'd2;
  localparam logic [2:0] ISS_LOW_FPS = 3'd3;
  localparam logic [2:0] ISS_THERMAL = 3'd4;
  localparam logic [2:0] ISS_POWER = 3'd5;
  localparam logic [2:0] ISS_UPDATE = 3'd6;

  localparam logic [5:0] SUG_CLOSE_BG = 6'd1;
  localparam logic [5:0] SUG_CHECK_MEM = 6'd2;
  localparam logic [5:0] SUG_LOWER_DETAIL = 6'd4;
  localparam logic [5:0] SUG_REDUCE_MOTION = 6'd8;
  localparam logic [5:0] SUG_COOL = 6'd16;
  localparam logic [5:0] SUG_WAIT = 6'd32;

  localparam logic [2:0] REG_MEM_FAIR = 3'd0;
  localparam logic [2:0] REG_MEM_POOR = 3'd1;
  localparam logic [2:0] REG_MEM_CRIT = 3'd2;
  localparam logic [2:0] REG_STUT_NUM = 3'd3;
  localparam logic [2:0] REG_STUT_DEN = 3'd4;
  localparam logic [2:0] REG_FPS_FLOOR = 3'd5;

  typedef struct packed {
    logic [1:0]      kind;
    logic [FT_W-1:0] frame_time;
    logic [7:0]      mem_load;
    logic [19:0]     frame_budget;
    logic [19:0]     fps_rate;
    logic            is_throttled;
    logic            eco_governor;
    logic            update_waiting;
  } item_t;

  typedef struct packed {
    logic [7:0]  mem_fair_level;
    logic [7:0]  mem_poor_level;
    logic [7:0]  mem_critical_level;
    logic [7:0]  stutter_numerator;
    logic [7:0]  stutter_denominator;
    logic [19:0] low_fps_floor;
  } cfg_t;

  typedef struct packed {
    logic            status;
    logic [FT_W-1:0] median_time;
    logic [FT_W-1:0] p95_time;
    logic [FT_W-1:0] worst_time;
    logic [6:0]      sample_count;
    logic [1:0]      health;
    logic [2:0]      issue;
    logic [5:0]      suggestions;
  } res_t;

endpackage

@@ sv/fthp_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps
module fthp_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/fthp_front.sv @@
// front end: takes requests, classifies them and queues them for the back end
`timescale 1ns / 1ps
module fthp_front import fthp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,
  input  logic        in_tuser,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  item_t       slot_r [2];
  logic        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  item_t       cls;
  logic        push;

  always_comb begin
    cls.frame_time     = in_tdata[19:0];
    cls.mem_load       = in_tdata[27:20];
    cls.frame_budget   = in_tdata[47:28];
    cls.fps_rate       = in_tdata[67:48];
    cls.is_throttled   = in_tdata[68];
    cls.eco_governor   = in_tdata[69];
    cls.update_waiting = in_tdata[70];
    if (in_tuser) begin
      cls.kind = KIND_ASSESS;
    end else if (cls.frame_time == '0 || cls.frame_time > FRAME_MAX_US) begin
      cls.kind = KIND_BAD;
    end else begin
      cls.kind = KIND_RECORD;
    end
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = slot_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= cls;
    end
  end

endmodule

@@ sv/fthp_back.sv @@
// back end: sample window, order statistic search, pacing divider and rule ladder
`timescale 1ns / 1ps
module fthp_back import fthp_pkg::*; #(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       q_valid,
  input  item_t      q_item,
  output logic       q_pop,
  output logic       res_valid,
  input  logic       res_ready,
  output res_t       res,
  output logic [$clog2(WINDOW_DEPTH+1)-1:0] fill_count
);

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int XW = $clog2(WINDOW_DEPTH * 95 + 100);
  localparam int PW = XW + 18;
  localparam int KW = PW - RECIP_SHIFT;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_LADDER = 2'd3;

  logic [1:0]      state_r;
  logic [AW-1:0]   wp_r, idx_r, nlast;
  logic [CW-1:0]   fill_r, n_r;
  logic            iss_r, dv_r, dl_r;
  logic [4:0]      bit_r;
  logic [CW-1:0]   cnt_r [3];
  logic [CW-1:0]   k_r [3];
  logic [FT_W-1:0] pfx_r [3];
  logic [7:0]      rem_r;
  logic [19:0]     q_r;
  logic [4:0]      dcnt_r;
  logic [XW-1:0]   x_r;
  logic [PW-1:0]   prod_r;
  logic [27:0]     lim_r;
  item_t           item_r;
  logic            ov_r;
  res_t            ores_r;

  logic            can_out, ram_we, ov_set;
  logic [FT_W-1:0] rdata, mask;
  logic [CW-1:0]   csum [3];
  logic [8:0]      dtry;
  logic [7:0]      den_eff;
  logic            dbit;
  logic [KW-1:0]   c95;
  logic [CW-1:0]   k95;
  res_t            lad;
  res_t            brief_res;

  fthp_ram #(.WIDTH(FT_W), .DEPTH(WINDOW_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (q_item.frame_time),
    .raddr (idx_r),
    .rdata (rdata)
  );

  assign can_out    = !ov_r || res_ready;
  assign q_pop      = (state_r == ST_IDLE) && q_valid && can_out;
  assign ram_we     = q_pop && (q_item.kind == KIND_RECORD);
  assign res_valid  = ov_r;
  assign res        = ores_r;
  assign fill_count = fill_r;
  assign nlast      = AW'(n_r - CW'(1));
  assign mask       = {FT_W{1'b1}} << ({1'b0, bit_r} + 6'd1);
  assign ov_set     = (q_pop && !(q_item.kind == KIND_ASSESS && fill_r >= CW'(MIN_SAMPLES)))
                      || (state_r == ST_LADDER && can_out);

  always_comb begin
    brief_res        = '0;
    brief_res.status = (q_item.kind != KIND_RECORD);
  end

  always_comb begin
    den_eff = (cfg.stutter_denominator == 8'd0) ? 8'd1 : cfg.stutter_denominator;
    dtry    = {rem_r, q_r[19]};
    dbit    = (dtry >= {1'b0, den_eff});
    c95     = prod_r[PW-1:RECIP_SHIFT] - KW'(1);
    k95     = (c95 >= KW'(n_r)) ? CW'(n_r - CW'(1)) : CW'(c95);
    for (int t = 0; t < 3; t++) begin
      csum[t] = cnt_r[t] + CW'(dv_r && (((rdata ^ pfx_r[t]) & mask) == '0)
                                 && !rdata[bit_r]);
    end
  end

  function automatic logic [1:0] raise(input logic [1:0] a, input logic [1:0] b);
    raise = (a > b) ? a : b;
  endfunction

  always_comb begin
    logic [1:0] sev;
    logic [2:0] iss;
    logic [5:0] sug;
    sev = 2'd0;
    iss = ISS_NONE;
    sug = '0;
    if (item_r.mem_load >= cfg.mem_critical_level) begin
      sev = 2'd3;
      iss = ISS_MEMORY;
      sug = sug | SUG_CLOSE_BG | SUG_CHECK_MEM;
    end else if (item_r.mem_load >= cfg.mem_poor_level) begin
      sev = 2'd2;
      iss = ISS_MEMORY;
      sug = sug | SUG_CHECK_MEM;
    end else if (item_r.mem_load >= cfg.mem_fair_level) begin
      sev = 2'd1;
      sug = sug | SUG_CHECK_MEM;
    end
    if (item_r.frame_budget != '0 && 28'(pfx_r[1]) > lim_r) begin
      sev = raise(sev, (29'(pfx_r[1]) > {lim_r, 1'b0}) ? 2'd3 : 2'd2);
      iss = ISS_STUTTER;
      sug = sug | SUG_LOWER_DETAIL | SUG_REDUCE_MOTION;
    end
    if (item_r.fps_rate != '0 && item_r.fps_rate < cfg.low_fps_floor) begin
      sev = raise(sev, (item_r.fps_rate < (cfg.low_fps_floor >> 1)) ? 2'd3 : 2'd2);
      if (iss == ISS_NONE || iss == ISS_MEMORY) begin
        iss = ISS_LOW_FPS;
      end
      sug = sug | SUG_LOWER_DETAIL;
    end
    if (item_r.is_throttled) begin
      sev = raise(sev, 2'd1);
      if (iss == ISS_NONE) begin
        iss = ISS_THERMAL;
      end
      sug = sug | SUG_COOL;
    end else if (item_r.eco_governor && (iss == ISS_STUTTER || iss == ISS_LOW_FPS)) begin
      sev = raise(sev, 2'd1);
      iss = ISS_POWER;
    end
    if (item_r.update_waiting) begin
      sev = raise(sev, 2'd1);
      if (iss == ISS_NONE) begin
        iss = ISS_UPDATE;
      end
      sug = sug | SUG_WAIT;
    end
    lad.status       = 1'b0;
    lad.median_time  = pfx_r[0];
    lad.p95_time     = pfx_r[1];
    lad.worst_time   = pfx_r[2];
    lad.sample_count = 7'(n_r);
    lad.health       = sev;
    lad.issue        = iss;
    lad.suggestions  = sug;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wp_r    <= '0;
      fill_r  <= '0;
      ov_r    <= 1'b0;
      iss_r   <= 1'b0;
      dv_r    <= 1'b0;
      dl_r    <= 1'b0;
    end else begin
      if (ov_set) begin
        ov_r <= 1'b1;
      end else if (res_valid && res_ready) begin
        ov_r <= 1'b0;
      end
      dv_r <= (state_r == ST_SCAN) && iss_r;
      dl_r <= (state_r == ST_SCAN) && iss_r && (idx_r == nlast);
      case (state_r)
        ST_IDLE: begin
          if (q_pop) begin
            if (q_item.kind == KIND_RECORD) begin
              wp_r <= (wp_r == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_r + AW'(1);
              if (fill_r < CW'(WINDOW_DEPTH)) begin
                fill_r <= fill_r + CW'(1);
              end
            end else if (q_item.kind == KIND_ASSESS && fill_r >= CW'(MIN_SAMPLES)) begin
              state_r <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (dcnt_r == 5'd19) begin
            state_r <= ST_SCAN;
            iss_r   <= 1'b1;
          end
        end
        ST_SCAN: begin
          if (iss_r && idx_r == nlast) begin
            iss_r <= 1'b0;
          end
          if (dl_r) begin
            if (bit_r == 5'd0) begin
              state_r <= ST_LADDER;
            end else begin
              iss_r <= 1'b1;
            end
          end
        end
        ST_LADDER: begin
          if (can_out) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= PW'(x_r) * PW'(RECIP_100);
    lim_r  <= 28'(q_r) * 28'(cfg.stutter_numerator);
    case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          ores_r        <= brief_res;
          item_r        <= q_item;
          n_r           <= fill_r;
          x_r           <= XW'(fill_r) * XW'(95) + XW'(99);
          rem_r         <= '0;
          q_r           <= q_item.frame_budget;
          dcnt_r        <= '0;
        end
      end
      ST_DIV: begin
        rem_r  <= dbit ? 8'(dtry - {1'b0, den_eff}) : dtry[7:0];
        q_r    <= {q_r[18:0], dbit};
        dcnt_r <= dcnt_r + 5'd1;
        if (dcnt_r == 5'd19) begin
          k_r[0] <= n_r >> 1;
          k_r[1] <= k95;
          k_r[2] <= n_r - CW'(1);
          for (int t = 0; t < 3; t++) begin
            pfx_r[t] <= '0;
            cnt_r[t] <= '0;
          end
          bit_r <= 5'd19;
          idx_r <= '0;
        end
      end
      ST_SCAN: begin
        if (iss_r && idx_r != nlast) begin
          idx_r <= idx_r + AW'(1);
        end
        if (dl_r) begin
          for (int t = 0; t < 3; t++) begin
            cnt_r[t] <= '0;
            if (k_r[t] >= csum[t]) begin
              pfx_r[t][bit_r] <= 1'b1;
              k_r[t]          <= k_r[t] - csum[t];
            end
          end
          bit_r <= bit_r - 5'd1;
          idx_r <= '0;
        end else begin
          for (int t = 0; t < 3; t++) begin
            cnt_r[t] <= csum[t];
          end
        end
      end
      ST_LADDER: begin
        if (can_out) begin
          ores_r <= lad;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ sv/frame_time_percentile_health.sv @@
// top level of the frame time percentile health monitor
`timescale 1ns / 1ps
// Record requests store a frame time into a window of WINDOW_DEPTH samples and
// return a result; out-of-range times are flagged and not stored. An
// assess request ranks the window with a bit-serial order statistic search that
// reads the sample memory once per bit of the 20-bit frame time, one sample at a
// time through its single read port, after a 20-step divider for the pacing limit.
// Requests are queued two deep ahead of the back end and the result sits in an
// output register. No clearing pass is needed after reset.
module frame_time_percentile_health import fthp_pkg::*; #(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // frame_time, memory pressure, frame_budget, fps_rate, is_throttled, eco_governor,
  // update_waiting
  input  logic [71:0] in_tdata,
  // op
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // median_time, p95_time, worst_time, sample_count, health, issue, suggestions
  output logic [79:0] out_tdata,
  // status
  output logic        out_tuser
);

  cfg_t   cfg_r;
  logic   q_valid, q_pop;
  item_t  q_item;
  res_t   res;
  logic [$clog2(WINDOW_DEPTH+1)-1:0] fill_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mem_fair_level      <= 8'd50;
      cfg_r.mem_poor_level      <= 8'd75;
      cfg_r.mem_critical_level  <= 8'd90;
      cfg_r.stutter_numerator   <= 8'd3;
      cfg_r.stutter_denominator <= 8'd2;
      cfg_r.low_fps_floor       <= 20'd30000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MEM_FAIR:  cfg_r.mem_fair_level      <= cfg_wdata[7:0];
        REG_MEM_POOR:  cfg_r.mem_poor_level      <= cfg_wdata[7:0];
        REG_MEM_CRIT:  cfg_r.mem_critical_level  <= cfg_wdata[7:0];
        REG_STUT_NUM:  cfg_r.stutter_numerator   <= cfg_wdata[7:0];
        REG_STUT_DEN:  cfg_r.stutter_denominator <= cfg_wdata[7:0];
        REG_FPS_FLOOR: cfg_r.low_fps_floor       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  fthp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  fthp_back #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res),
    .fill_count (fill_count)
  );

  assign out_tuser = res.status;
  assign out_tdata = {2'b00, res.suggestions, res.issue, res.health, res.sample_count,
                      res.worst_time, res.p95_time, res.median_time};

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_count <= ($clog2(WINDOW_DEPTH+1))'(WINDOW_DEPTH))
    else $error("fill count beyond window depth");

  a_good_no_issue: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser && res.health == 2'd0 |-> res.issue == ISS_NONE)
    else $error("issue reported with good health");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      res.median_time <= res.p95_time && res.p95_time <= res.worst_time)
    else $error("order statistics out of order");
`endif

endmodule
